FILE: rtl/prpu_pkg.sv
// Shared constants and types of the page replacement policy unit.
`default_nettype none
package prpu_pkg;

   localparam int PAGE_ID_W = 8;
   localparam int POLICY_W = 2;
   localparam int NUM_FRAMES_DEF = 4;
   localparam int PAGE_BITS_DEF = 8;

   localparam logic [POLICY_W-1:0] POLICY_FIFO = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_LRU = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_SC = 2'd2;

   localparam int RSP_FIELDS_W = 2 + PAGE_ID_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_DATA_W - RSP_FIELDS_W;

   typedef struct packed {
      logic [PAGE_ID_W-1:0] evicted_page;
      logic evicted_valid;
      logic page_fault;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/page_replacement_policy_unit.sv
// Top level of the page replacement policy unit: channels and pipeline registers.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  req_tdata: page_id
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: page_fault, evicted_valid, evicted_page
//   csr      in         csr_valid/csr_ready    csr_data: policy_mode
//
// One request is taken every cycle while req_tready is high; its response is registered.
// The rate is set by the frame table, which compares, selects and updates all frames together.
// After reset the policy is FIFO, every frame is empty and recency ranks follow frame order.
// The request register keeps filling while a response waits; req_tready falls only when
// both the request register and the response register are occupied and the response is stalled.
`default_nettype none
module page_replacement_policy_unit #(
   parameter int NUM_FRAMES = prpu_pkg::NUM_FRAMES_DEF,
   parameter int PAGE_BITS = prpu_pkg::PAGE_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [prpu_pkg::PAGE_ID_W-1:0] req_tdata,   // [7:0] page_id
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [prpu_pkg::RSP_DATA_W-1:0] rsp_tdata,       // [0] page_fault, [1] evicted_valid,
                                                            // [9:2] evicted_page
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [prpu_pkg::POLICY_W-1:0] csr_data      // [1:0] policy_mode
);

   logic req_valid_ff;
   logic [prpu_pkg::PAGE_ID_W-1:0] req_page_ff;
   logic rsp_valid_ff;
   prpu_pkg::result_type rsp_result_ff;
   logic [prpu_pkg::POLICY_W-1:0] policy_ff;
   prpu_pkg::result_type result;
   logic advance;

   assign advance = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{prpu_pkg::RSP_PAD_W{1'b0}}, rsp_result_ff};

   prpu_frame_table #(
      .NUM_FRAMES(NUM_FRAMES),
      .PAGE_BITS(PAGE_BITS)
   ) u_frame_table (
      .clock(clock),
      .reset(reset),
      .step(advance),
      .policy(policy_ff),
      .page_id(req_page_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         policy_ff <= prpu_pkg::POLICY_FIFO;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            policy_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_page_ff <= req_tdata;
      end
      if (advance) begin
         rsp_result_ff <= result;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/prpu_frame_table.sv
// Frame table with hit test, victim selection and per-policy book-keeping.
`default_nettype none
module prpu_frame_table #(
   parameter int NUM_FRAMES = prpu_pkg::NUM_FRAMES_DEF,
   parameter int PAGE_BITS = prpu_pkg::PAGE_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step,
   input  wire logic [prpu_pkg::POLICY_W-1:0] policy,
   input  wire logic [prpu_pkg::PAGE_ID_W-1:0] page_id,
   output prpu_pkg::result_type result
);

   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam int EXT_W = (PAGE_BITS > prpu_pkg::PAGE_ID_W) ? PAGE_BITS : prpu_pkg::PAGE_ID_W;

   logic [PAGE_BITS-1:0] page_ff [NUM_FRAMES];
   logic [PAGE_BITS-1:0] page_in [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0] rank_ff [NUM_FRAMES];
   logic [IDX_W-1:0] rank_in [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] ref_ff, ref_in;

   logic [EXT_W-1:0] page_ext;
   logic [PAGE_BITS-1:0] page;
   logic [EXT_W-1:0] evict_ext;
   logic [PAGE_BITS-1:0] evict_page;

   logic hit_any, inv_any, clear_any;
   logic [IDX_W-1:0] hit_idx, inv_idx, lru_idx, sc_idx, victim_idx, touch_idx;
   logic is_lru, is_sc;
   logic do_touch;
   logic [NUM_FRAMES-1:0] rank_seen;

   assign page_ext = EXT_W'(page_id);
   assign page = page_ext[PAGE_BITS-1:0];
   assign is_lru = (policy == prpu_pkg::POLICY_LRU);
   assign is_sc = (policy == prpu_pkg::POLICY_SC);

   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      inv_any = 1'b0;
      inv_idx = '0;
      clear_any = 1'b0;
      sc_idx = '0;
      lru_idx = '0;
      for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
         if (valid_ff[i] && page_ff[i] == page) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            inv_any = 1'b1;
            inv_idx = IDX_W'(i);
         end
         if (!ref_ff[i]) begin
            clear_any = 1'b1;
            sc_idx = IDX_W'(i);
         end
         if (rank_ff[i] == IDX_W'(NUM_FRAMES - 1)) begin
            lru_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      if (inv_any) begin
         victim_idx = inv_idx;
      end else if (is_lru) begin
         victim_idx = lru_idx;
      end else begin
         victim_idx = sc_idx;
      end
   end

   assign touch_idx = hit_any ? hit_idx : victim_idx;

   always_comb begin
      page_in = page_ff;
      valid_in = valid_ff;
      ref_in = ref_ff;
      do_touch = 1'b0;
      result.page_fault = !hit_any;
      result.evicted_valid = 1'b0;
      evict_page = '0;
      if (hit_any) begin
         if (is_lru) begin
            do_touch = 1'b1;
         end else if (is_sc) begin
            ref_in[hit_idx] = 1'b1;
         end
      end else if (is_lru || is_sc) begin
         if (!inv_any) begin
            result.evicted_valid = 1'b1;
            evict_page = page_ff[victim_idx];
         end
         page_in[victim_idx] = page;
         valid_in[victim_idx] = 1'b1;
         if (is_lru) begin
            do_touch = 1'b1;
         end else begin
            if (!inv_any) begin
               for (int i = 0; i < NUM_FRAMES; i++) begin
                  if (!clear_any || IDX_W'(i) < sc_idx) begin
                     ref_in[i] = 1'b0;
                  end
               end
            end
            ref_in[victim_idx] = 1'b0;
         end
      end else begin
         if (valid_ff[NUM_FRAMES-1]) begin
            result.evicted_valid = 1'b1;
            evict_page = page_ff[NUM_FRAMES-1];
         end
         for (int i = NUM_FRAMES - 1; i > 0; i--) begin
            page_in[i] = page_ff[i-1];
            valid_in[i] = valid_ff[i-1];
         end
         page_in[0] = page;
         valid_in[0] = 1'b1;
      end
      evict_ext = EXT_W'(evict_page);
      result.evicted_page = evict_ext[prpu_pkg::PAGE_ID_W-1:0];
   end

   // The touched frame becomes most recent and every more recent frame ages by one.
   always_comb begin
      rank_in = rank_ff;
      if (do_touch) begin
         for (int i = 0; i < NUM_FRAMES; i++) begin
            if (rank_ff[i] < rank_ff[touch_idx]) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
         rank_in[touch_idx] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ref_ff <= '0;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            rank_ff[i] <= IDX_W'(i);
         end
      end else if (step) begin
         valid_ff <= valid_in;
         ref_ff <= ref_in;
         rank_ff <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         page_ff <= page_in;
      end
   end

   always_comb begin
      rank_seen = '0;
      for (int r = 0; r < NUM_FRAMES; r++) begin
         for (int i = 0; i < NUM_FRAMES; i++) begin
            if (rank_ff[i] == IDX_W'(r)) begin
               rank_seen[r] = 1'b1;
            end
         end
      end
   end

`ifndef SYNTHESIS
   a_rank_permutation: assert property (@(posedge clock) disable iff (reset)
      &rank_seen)
      else $error("Recency ranks are not a permutation of the frames.");

   a_evict_needs_fault: assert property (@(posedge clock) disable iff (reset)
      step && result.evicted_valid |-> result.page_fault)
      else $error("A page was evicted on a hit.");

   a_valid_monotonic: assert property (@(posedge clock) disable iff (reset)
      step |=> $countones(valid_ff) >= $past($countones(valid_ff)))
      else $error("The number of occupied frames dropped.");

   a_sc_miss_clears: assert property (@(posedge clock) disable iff (reset)
      step && !hit_any && is_sc && !inv_any |=>
         $countones(ref_ff) <= $past($countones(ref_ff)))
      else $error("A second chance replacement set a reference bit.");
`endif

endmodule
`default_nettype wire

FILE: verif/page_replacement_policy_unit_test.sv
// Self-checking testbench for the page replacement policy unit with a frame-table predictor.
`default_nettype none
module page_replacement_policy_unit_test;

   localparam int FRAMES = prpu_pkg::NUM_FRAMES_DEF;
   localparam int RANK_W = $clog2(FRAMES);
   localparam int PAGE_W = prpu_pkg::PAGE_ID_W;
   localparam int POL_W = prpu_pkg::POLICY_W;
   localparam logic [POL_W-1:0] POLICY_UNDEF = 2'd3;
   localparam int STALL_LIMIT = 1000;
   localparam int LONG_HOLD = 60;

   class frame_table_tracker;
      logic [PAGE_W-1:0] frame_page [FRAMES];
      bit frame_valid [FRAMES];
      logic [RANK_W-1:0] recency [FRAMES];
      bit referenced [FRAMES];
      logic [POL_W-1:0] policy;
      prpu_pkg::result_type pending_outcomes [$];
      int unsigned mismatches;

      function new();
         for (int i = 0; i < FRAMES; i++) begin
            frame_page[i] = '0;
            frame_valid[i] = 1'b0;
            recency[i] = RANK_W'(i);
            referenced[i] = 1'b0;
         end
         policy = prpu_pkg::POLICY_FIFO;
         mismatches = 0;
      endfunction

      function void promote(int f);
         logic [RANK_W-1:0] old;
         old = recency[f];
         for (int i = 0; i < FRAMES; i++) begin
            if (recency[i] < old) recency[i] = recency[i] + 1'b1;
         end
         recency[f] = '0;
      endfunction

      function void note_reference(logic [PAGE_W-1:0] page);
         int hit;
         int victim;
         prpu_pkg::result_type outcome;
         hit = -1;
         victim = -1;
         outcome = '0;
         for (int i = 0; i < FRAMES; i++) begin
            if (hit < 0 && frame_valid[i] && frame_page[i] == page) hit = i;
         end
         if (hit >= 0) begin
            if (policy == prpu_pkg::POLICY_LRU) promote(hit);
            else if (policy == prpu_pkg::POLICY_SC) referenced[hit] = 1'b1;
         end else if (policy == prpu_pkg::POLICY_LRU || policy == prpu_pkg::POLICY_SC) begin
            for (int i = 0; i < FRAMES; i++) begin
               if (victim < 0 && !frame_valid[i]) victim = i;
            end
            if (victim < 0) begin
               if (policy == prpu_pkg::POLICY_LRU) begin
                  for (int i = FRAMES - 1; i >= 0; i--) begin
                     if (recency[i] == RANK_W'(FRAMES - 1)) victim = i;
                  end
               end else begin
                  for (int i = 0; i < FRAMES; i++) begin
                     if (victim < 0) begin
                        if (!referenced[i]) victim = i;
                        else referenced[i] = 1'b0;
                     end
                  end
               end
               if (victim < 0) victim = 0;
               outcome.evicted_valid = 1'b1;
               outcome.evicted_page = frame_page[victim];
            end
            frame_page[victim] = page;
            frame_valid[victim] = 1'b1;
            if (policy == prpu_pkg::POLICY_LRU) promote(victim);
            else referenced[victim] = 1'b0;
         end else begin
            if (frame_valid[FRAMES-1]) begin
               outcome.evicted_valid = 1'b1;
               outcome.evicted_page = frame_page[FRAMES-1];
            end
            for (int i = FRAMES - 1; i > 0; i--) begin
               frame_page[i] = frame_page[i-1];
               frame_valid[i] = frame_valid[i-1];
            end
            frame_page[0] = page;
            frame_valid[0] = 1'b1;
         end
         outcome.page_fault = (hit < 0);
         pending_outcomes.push_back(outcome);
      endfunction

      task report_mismatch(string field, int got, int want);
         $display("%0t: %s: got %0d, expected %0d", $realtime, field, got, want);
         mismatches++;
      endtask

      task check_outcome(logic [prpu_pkg::RSP_DATA_W-1:0] data);
         prpu_pkg::result_type got;
         prpu_pkg::result_type want;
         got = prpu_pkg::result_type'(data[prpu_pkg::RSP_FIELDS_W-1:0]);
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with no request pending", int'(got), 0);
         end else begin
            want = pending_outcomes.pop_front();
            if (got.page_fault !== want.page_fault)
               report_mismatch("page_fault", int'(got.page_fault), int'(want.page_fault));
            if (got.evicted_valid !== want.evicted_valid)
               report_mismatch("evicted_valid", int'(got.evicted_valid),
                               int'(want.evicted_valid));
            if (got.evicted_page !== want.evicted_page)
               report_mismatch("evicted_page", int'(got.evicted_page), int'(want.evicted_page));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [PAGE_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [prpu_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [POL_W-1:0] csr_data = '0;

   frame_table_tracker tracker = new();
   bit quiet_tail = 1'b0;
   bit hold_request = 1'b0;
   int gap_odds = 0;
   int idle_cycles = 0;

   page_replacement_policy_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_outcome(rsp_tdata);
         if (req_tvalid && req_tready) tracker.note_reference(req_tdata);
         if (csr_valid && csr_ready) tracker.policy = csr_data;
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("page_replacement_policy_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int run_left;
      int hold_left;
      bit hold_done;
      run_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (quiet_tail) begin
            rsp_tready <= 1'b1;
         end else if (run_left > 0) begin
            run_left--;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            run_left = $urandom_range(1, 12) - 1;
         end else begin
            rsp_tready <= 1'b1;
            run_left = $urandom_range(1, 24) - 1;
         end
      end
   end

   task automatic send_page(input logic [PAGE_W-1:0] page);
      req_tvalid <= 1'b1;
      req_tdata <= page;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!quiet_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic set_policy(input logic [POL_W-1:0] mode);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_outcomes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [PAGE_W-1:0] resident [FRAMES];
      logic [PAGE_W-1:0] base;
      logic [PAGE_W-1:0] page;
      int span;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      gap_odds = 3;

      // Page 0 must miss right after reset even though the predictor's empty frames hold zero.
      send_page(8'd0);
      set_policy(prpu_pkg::POLICY_SC);
      send_page(8'd0);
      send_page(8'd255);
      set_policy(prpu_pkg::POLICY_LRU);
      send_page(8'd1);
      send_page(8'd2);
      send_page(8'd0);
      send_page(8'd3);
      send_page(8'd255);

      // Touch every resident page so that all reference bits are set before the miss.
      set_policy(prpu_pkg::POLICY_SC);
      for (int i = 0; i < FRAMES; i++) resident[i] = tracker.frame_page[i];
      for (int i = 0; i < FRAMES; i++) send_page(resident[i]);
      send_page(8'd77);
      send_page(8'd78);
      set_policy(prpu_pkg::POLICY_FIFO);
      send_page(8'd127);
      send_page(8'd128);
      send_page(8'd78);
      set_policy(POLICY_UNDEF);
      send_page(8'd255);
      send_page(8'd170);

      for (int phase = 0; phase < 10; phase++) begin
         case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 2;
            default: gap_odds = 5;
         endcase
         quiet_tail = (phase == 9);
         set_policy(phase < 4 ? POL_W'(phase) : POL_W'($urandom_range(0, 3)));
         base = PAGE_W'($urandom_range(0, 255));
         span = $urandom_range(3, 9);
         for (int n = 0; n < 128; n++) begin
            if (phase == 2 && n == 20) hold_request = 1'b1;
            if ($urandom_range(0, 9) == 0) page = PAGE_W'($urandom_range(0, 255));
            else page = base + PAGE_W'($urandom_range(0, span));
            send_page(page);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_outcomes.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("page_replacement_policy_unit: match");
      else
         $display("page_replacement_policy_unit: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
